// ===== hdl/wsid_pkg.sv =====
// Shared widths, limits and controller/datapath interface types for the wine selling DP unit.
package wsid_pkg;

    localparam int unsigned PRICE_W         = 16;
    localparam int unsigned REVENUE_W       = 28;
    localparam logic [REVENUE_W-1:0] REVENUE_MAX = '1;
    localparam int unsigned MAX_BOTTLES_DEF = 64;

    typedef struct packed {
        logic load;
        logic start;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic row_last;
        logic len_last;
        logic pipe_empty;
    } status_t;

endpackage

// ===== hdl/wine_selling_interval_dp_unit.sv =====
// Top level of the wine selling interval DP unit.
//
// Input channel (s_*): one price per beat, s_last marks the final price of a row.
// Prices beyond MAX_BOTTLES are dropped and reported in m_overflow.
// Output channel (m_*): one beat per row with the best revenue and the overflow flag.
// After the last beat the unit evaluates one interval cell per cycle through a
// three stage pipeline (RAM read, multiply, add/compare/write back), and waits
// for the pipeline to drain between lengths. For a row of n prices m_valid
// rises once all n*(n+1)/2 interval cells have been written back and the
// pipeline has drained.
// s_ready is low during the computation. Prices of the next row are taken while
// a result waits in the output register, but its last beat waits until that
// result is taken. A stalled receiver holds m_valid and the result steady.
// Reset (aresetn, synchronous, active low) clears the price count, the dropped-price
// flag and the output valid; the stores and the m_overflow register need no clearing.
module wine_selling_interval_dp_unit #(
    parameter int unsigned MAX_BOTTLES = wsid_pkg::MAX_BOTTLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wsid_pkg::PRICE_W-1:0]    s_price,
    input  logic                            s_last,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wsid_pkg::REVENUE_W-1:0]  m_best_revenue,
    output logic                            m_overflow
);
    import wsid_pkg::*;

    cmd_t    cmd;
    status_t status;

    wsid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status)
    );

    wsid_dp #(.MAX_BOTTLES(MAX_BOTTLES)) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .s_price      (s_price),
        .status       (status),
        .best_revenue (m_best_revenue),
        .overflow     (m_overflow)
    );

endmodule

// ===== hdl/wsid_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module wsid_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AddrW-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AddrW-1:0] raddr0,
    input  logic [AddrW-1:0] raddr1,
    output logic [WIDTH-1:0] rdata0,
    output logic [WIDTH-1:0] rdata1
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata0_reg <= mem_reg[raddr0];
        rdata1_reg <= mem_reg[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

// ===== hdl/wsid_dp.sv =====
// Datapath: price store, interval table, cell pipeline and result registers.
module wsid_dp #(
    parameter int unsigned MAX_BOTTLES = wsid_pkg::MAX_BOTTLES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wsid_pkg::cmd_t                  cmd,
    input  logic [wsid_pkg::PRICE_W-1:0]    s_price,
    output wsid_pkg::status_t               status,
    output logic [wsid_pkg::REVENUE_W-1:0]  best_revenue,
    output logic                            overflow
);
    import wsid_pkg::*;

    localparam int unsigned CntW  = $clog2(MAX_BOTTLES + 1);
    localparam int unsigned AddrW = (MAX_BOTTLES > 1) ? $clog2(MAX_BOTTLES) : 1;
    localparam longint unsigned PeakRev = ((longint'(1) << PRICE_W) - 1)
                                        * longint'(MAX_BOTTLES)
                                        * longint'(MAX_BOTTLES + 1) / 2;
    localparam int unsigned BestW = $clog2(PeakRev + 1);
    localparam int unsigned ProdW = PRICE_W + CntW;
    localparam int unsigned SumW  = ((ProdW > BestW) ? ProdW : BestW) + 1;
    localparam int unsigned CmpW  = (BestW > REVENUE_W) ? BestW : REVENUE_W;
    localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BOTTLES);

    logic [CntW-1:0]      count_reg;
    logic                 dropped_reg;
    logic [CntW-1:0]      n_reg;
    logic [CntW-1:0]      len_reg;
    logic [AddrW-1:0]     i_reg;

    logic                 v1_reg, v2_reg;
    logic                 fin1_reg, fin2_reg;
    logic                 one1_reg;
    logic [AddrW-1:0]     addr1_reg, addr2_reg;
    logic [CntW-1:0]      day1_reg;
    logic [ProdW-1:0]     prod_l_reg, prod_r_reg;
    logic [BestW-1:0]     best_l_reg, best_r_reg;
    logic [REVENUE_W-1:0] best_revenue_reg;
    logic                 overflow_reg;

    logic [CntW-1:0]      day;
    logic [CntW:0]        row_sum;
    logic [CntW-1:0]      right_idx;
    logic                 store_we;
    logic [PRICE_W-1:0]   price_l, price_r;
    logic [BestW-1:0]     best_next, best_same;
    logic [SumW-1:0]      sum_l, sum_r;
    logic [BestW-1:0]     best_w;
    logic [CmpW-1:0]      best_wide;

    assign day       = n_reg - len_reg + CntW'(1);
    assign row_sum   = (CntW+1)'(i_reg) + (CntW+1)'(len_reg);
    assign right_idx = CntW'(i_reg) + len_reg - CntW'(1);
    assign store_we  = cmd.load && (count_reg < MaxCnt);

    assign status.row_last   = (row_sum == (CntW+1)'(n_reg));
    assign status.len_last   = (len_reg == n_reg);
    assign status.pipe_empty = !v1_reg && !v2_reg;

    wsid_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_BOTTLES)) u_price_ram (
        .aclk   (aclk),
        .we     (store_we),
        .waddr  (count_reg[AddrW-1:0]),
        .wdata  (s_price),
        .raddr0 (i_reg),
        .raddr1 (right_idx[AddrW-1:0]),
        .rdata0 (price_l),
        .rdata1 (price_r)
    );

    wsid_ram #(.WIDTH(BestW), .DEPTH(MAX_BOTTLES)) u_best_ram (
        .aclk   (aclk),
        .we     (v2_reg),
        .waddr  (addr2_reg),
        .wdata  (best_w),
        .raddr0 (i_reg + AddrW'(1)),
        .raddr1 (i_reg),
        .rdata0 (best_next),
        .rdata1 (best_same)
    );

    assign sum_l     = SumW'(prod_l_reg) + SumW'(best_l_reg);
    assign sum_r     = SumW'(prod_r_reg) + SumW'(best_r_reg);
    assign best_w    = (sum_l > sum_r) ? sum_l[BestW-1:0] : sum_r[BestW-1:0];
    assign best_wide = CmpW'(best_w);

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            fin1_reg    <= 1'b0;
            fin2_reg    <= 1'b0;
        end else begin
            v1_reg   <= cmd.issue;
            v2_reg   <= v1_reg;
            fin1_reg <= cmd.issue && (len_reg == n_reg);
            fin2_reg <= fin1_reg;
            if (cmd.load) begin
                if (count_reg < MaxCnt) begin
                    count_reg <= count_reg + CntW'(1);
                end else begin
                    dropped_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end
        end
    end

    // interval counters and cell pipeline
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            n_reg   <= count_reg;
            len_reg <= CntW'(1);
            i_reg   <= '0;
        end else if (cmd.issue) begin
            if (status.row_last) begin
                i_reg   <= '0;
                len_reg <= len_reg + CntW'(1);
            end else begin
                i_reg <= i_reg + AddrW'(1);
            end
        end

        addr1_reg <= i_reg;
        day1_reg  <= day;
        one1_reg  <= (len_reg == CntW'(1));

        addr2_reg  <= addr1_reg;
        prod_l_reg <= ProdW'(price_l) * ProdW'(day1_reg);
        prod_r_reg <= ProdW'(price_r) * ProdW'(day1_reg);
        best_l_reg <= one1_reg ? '0 : best_next;
        best_r_reg <= one1_reg ? '0 : best_same;

        if (v2_reg && fin2_reg) begin
            best_revenue_reg <= (best_wide > CmpW'(REVENUE_MAX)) ? REVENUE_MAX
                                                                 : best_wide[REVENUE_W-1:0];
        end
        if (cmd.finish) begin
            overflow_reg <= dropped_reg;
        end
    end

    assign best_revenue = best_revenue_reg;
    assign overflow     = overflow_reg;

`ifndef SYNTHESIS
    a_issue_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (len_reg != '0) && (len_reg <= n_reg))
        else $error("cell issued outside the interval length range");
    a_final_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (v2_reg && fin2_reg) |-> !v1_reg)
        else $error("cell in flight behind the final cell");
    a_row_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> (count_reg != '0))
        else $error("computation started on an empty row");
`endif

endmodule

// ===== hdl/wsid_ctrl.sv =====
// Controller: load, cell issue, row drain and result hand-off sequencing.
module wsid_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_last,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output wsid_pkg::cmd_t     cmd,
    input  wsid_pkg::status_t  status
);
    import wsid_pkg::*;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_START = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready    = (state_reg == ST_LOAD) && !(s_last && m_valid_reg);
    assign cmd.load   = s_valid && s_ready;
    assign cmd.start  = (state_reg == ST_START);
    assign cmd.issue  = (state_reg == ST_RUN);
    assign cmd.finish = (state_reg == ST_FLUSH) && status.pipe_empty;
    assign m_valid    = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (cmd.load && s_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (status.row_last) begin
                    state_next = status.len_last ? ST_FLUSH : ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_RUN;
                end
            end
            ST_FLUSH: begin
                if (status.pipe_empty) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_finish_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("result not presented after finish");
    a_last_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |-> !m_valid_reg)
        else $error("last beat taken while a result is pending");
    a_start_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> status.pipe_empty)
        else $error("computation started with cells in flight");
`endif

endmodule
